// ===== sv/dted_pkg.sv =====
// ----------------------------------------------------------------------------
// dted_pkg: shared types and constants for the drain tank empty detector
// Register map, command and decision codes, item and result structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dted_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int FLOW_W  = 16;
    localparam int PWM_W   = 10;
    localparam int PCT_W   = 7;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // product of a flow value and a percentage
    localparam int PROD_W  = FLOW_W + PCT_W;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [CNT_W-1:0] CNT_MAX  = 4'd15;

    // register reset values
    localparam logic [PCT_W-1:0]  DROP_PCT_RST       = 7'd30;
    localparam logic [15:0]       MIN_RUN_MS_RST     = 16'd8000;
    localparam logic [PWM_W-1:0]  PWM_GATE_LEVEL_RST = 10'd512;
    localparam logic [FLOW_W-1:0] MIN_PEAK_FLOW_RST  = 16'd200;
    localparam logic [CNT_W-1:0]  CONFIRM_RST        = 4'd4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP_PCT       = 3'd0,
        CFG_MIN_RUN_MS     = 3'd1,
        CFG_PWM_GATE_LEVEL = 3'd2,
        CFG_MIN_PEAK_FLOW  = 3'd3,
        CFG_CONFIRM_NEEDED = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        DEC_KEEP    = 2'd0,
        DEC_NO_FLOW = 2'd1,
        DEC_EMPTY   = 2'd2
    } decision_t;

    // live configuration; drop_keep is 100 minus the clamped drop percentage
    typedef struct packed {
        logic [PCT_W-1:0]  drop_keep;
        logic [15:0]       min_run_ms;
        logic [PWM_W-1:0]  pwm_gate_level;
        logic [FLOW_W-1:0] min_peak_flow;
        logic [CNT_W-1:0]  confirm_needed;
    } cfg_t;

    typedef struct packed {
        command_t          command;
        logic [TIME_W-1:0] now_ms;
        logic [FLOW_W-1:0] flow_ml_min;
        logic              pump_enabled;
        logic              loop_active;
        logic              loop_settled;
        logic [PWM_W-1:0]  pump_pwm;
    } item_t;

    typedef struct packed {
        decision_t         decision;
        logic [FLOW_W-1:0] peak_flow;
        logic [CNT_W-1:0]  drop_count;
        logic              armed;
    } result_t;

endpackage

// ===== sv/drain_tank_empty_detector.sv =====
// ----------------------------------------------------------------------------
// drain_tank_empty_detector: stops a drain session when the tank runs dry
// Items pass the input register, core stage (session state update) and result
// register; one item per cycle while m_axis_tready does not stall the output.
// Async active-low reset: session state zero, registers at defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drain_tank_empty_detector
    import dted_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] now_ms, [47:32] flow_ml_min, [48] pump_enabled, [49] loop_active,
    // [50] loop_settled, [60:51] pump_pwm, [63:61] zero
    input  logic [63:0]           s_axis_tdata,
    // [0] command
    input  logic [0:0]            s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] decision, [17:2] peak_flow, [21:18] drop_count, [22] armed, [23] zero
    output logic [23:0]           m_axis_tdata,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg, item_next;
    logic    in_valid_reg, in_valid_next;
    result_t core_res;
    result_t res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    in_xfer;

    assign cfg_ready = 1'b1;

    dted_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // stage handshakes
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // unpack the input transfer
    always_comb
    begin
        item_next.command      = command_t'(s_axis_tuser[0]);
        item_next.now_ms       = s_axis_tdata[31:0];
        item_next.flow_ml_min  = s_axis_tdata[47:32];
        item_next.pump_enabled = s_axis_tdata[48];
        item_next.loop_active  = s_axis_tdata[49];
        item_next.loop_settled = s_axis_tdata[50];
        item_next.pump_pwm     = s_axis_tdata[60:51];
    end

    assign in_valid_next  = in_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_axis_tready);

    // input register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg <= item_next;
        end
    end

    dted_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (core_res)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, res_reg.armed, res_reg.drop_count,
                            res_reg.peak_flow, res_reg.decision};

`ifndef SYNTHESIS
    // a stop is only ever issued while armed
    a_stop_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (res_reg.decision != DEC_KEEP)) |-> res_reg.armed)
        else $error("stop decision without armed");

    // a no-flow stop means the peak stayed under the minimum
    a_noflow_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (res_reg.decision == DEC_NO_FLOW)) |->
        (res_reg.peak_flow < cfg.min_peak_flow))
        else $error("no-flow stop with peak at or above minimum");

    // an item leaving the core stage shows up as a result
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("core advanced without a result");
`endif

endmodule

// ===== sv/dted_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dted_cfg_regs: configuration register file
// Takes register writes and keeps the detector settings. The drop
// percentage is clamped and turned into the kept fraction at write time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dted_cfg_regs
    import dted_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [PCT_W-1:0] pct_in;

    // kept fraction of the peak: 100 - min(pct, 100)
    assign pct_in = wr_data[PCT_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_DROP_PCT:
                begin
                    cfg_next.drop_keep = (pct_in > PCT_FULL) ? '0 : (PCT_FULL - pct_in);
                end
                CFG_MIN_RUN_MS:     cfg_next.min_run_ms     = wr_data[15:0];
                CFG_PWM_GATE_LEVEL: cfg_next.pwm_gate_level = wr_data[PWM_W-1:0];
                CFG_MIN_PEAK_FLOW:  cfg_next.min_peak_flow  = wr_data[FLOW_W-1:0];
                CFG_CONFIRM_NEEDED: cfg_next.confirm_needed = wr_data[CNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drop_keep      <= PCT_FULL - DROP_PCT_RST;
            cfg_reg.min_run_ms     <= MIN_RUN_MS_RST;
            cfg_reg.pwm_gate_level <= PWM_GATE_LEVEL_RST;
            cfg_reg.min_peak_flow  <= MIN_PEAK_FLOW_RST;
            cfg_reg.confirm_needed <= CONFIRM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/dted_core.sv =====
// ----------------------------------------------------------------------------
// dted_core: session state and empty decision
// Holds start time, peak flow, drop counter and finished latch, and works
// out one result per item combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dted_core
    import dted_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [TIME_W-1:0] run_start_reg, run_start_next;
    logic [FLOW_W-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              fin_reg, fin_next;

    logic              running;
    logic              gated;
    logic [TIME_W-1:0] elapsed;
    logic              raise;
    logic [FLOW_W-1:0] peak_upd;
    logic [CNT_W-1:0]  cnt_base;
    logic [CNT_W-1:0]  cnt_inc;
    logic              armed;
    logic [PROD_W-1:0] thresh_scaled;
    logic [PROD_W-1:0] flow_scaled;
    logic              below;

    // gating and elapsed time
    assign running = item.pump_enabled && !fin_reg;
    assign gated   = !item.loop_active || item.loop_settled ||
                     (item.pump_pwm >= cfg.pwm_gate_level);
    assign elapsed = item.now_ms - run_start_reg;
    assign armed   = running && (elapsed >= TIME_W'(cfg.min_run_ms)) && gated;

    // peak tracking; a new peak restarts the count
    assign raise    = running && (item.flow_ml_min > peak_reg);
    assign peak_upd = raise ? item.flow_ml_min : peak_reg;
    assign cnt_base = raise ? '0 : cnt_reg;
    assign cnt_inc  = (cnt_base == CNT_MAX) ? CNT_MAX : (cnt_base + 1'b1);

    // flow < floor(peak*keep/100)  <=>  100*flow + 100 <= peak*keep
    assign thresh_scaled = PROD_W'(peak_upd) * PROD_W'(cfg.drop_keep);
    assign flow_scaled   = PROD_W'(item.flow_ml_min) * PROD_W'(PCT_FULL) + PROD_W'(PCT_FULL);
    assign below         = flow_scaled <= thresh_scaled;

    // next state and result
    always_comb
    begin
        run_start_next    = run_start_reg;
        peak_next         = peak_reg;
        cnt_next          = cnt_reg;
        fin_next          = fin_reg;
        result.decision   = DEC_KEEP;
        result.armed      = 1'b0;
        if (item.command == CMD_START)
        begin
            run_start_next = item.now_ms;
            peak_next      = '0;
            cnt_next       = '0;
            fin_next       = 1'b0;
        end
        else
        begin
            peak_next    = peak_upd;
            cnt_next     = cnt_base;
            result.armed = armed;
            if (armed)
            begin
                if (peak_upd < cfg.min_peak_flow)
                begin
                    result.decision = DEC_NO_FLOW;
                    fin_next        = 1'b1;
                end
                else if (below)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= cfg.confirm_needed)
                    begin
                        result.decision = DEC_EMPTY;
                        fin_next        = 1'b1;
                    end
                end
                else
                begin
                    cnt_next = '0;
                end
            end
        end
        result.peak_flow  = peak_next;
        result.drop_count = cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg <= '0;
            peak_reg      <= '0;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
        end
        else if (advance)
        begin
            run_start_reg <= run_start_next;
            peak_reg      <= peak_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
        end
    end

endmodule

// ===== dv/dted_check.sv =====
// ----------------------------------------------------------------------------
// dted_check: result checker for the drain tank empty detector
// Watches the input, result and register write channels, keeps its own copy
// of the session state and registers, predicts one result per input
// transfer and compares every result transfer against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dted_check
    import dted_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [63:0]           s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [23:0]           m_axis_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_seen,
    output int                    armed_seen,
    output int                    no_flow_stops,
    output int                    empty_stops
);

    localparam int MAX_REPORTED = 10;

    // register copies
    logic [PCT_W-1:0]  drop_pct_set;
    logic [15:0]       min_run_set;
    logic [PWM_W-1:0]  gate_set;
    logic [FLOW_W-1:0] min_peak_set;
    logic [CNT_W-1:0]  confirm_set;

    // session state copies
    logic [TIME_W-1:0] session_start;
    logic [FLOW_W-1:0] peak_hold;
    logic [CNT_W-1:0]  drop_run;
    logic              stopped;

    result_t due_results[$];
    item_t   sample_in;
    result_t want;
    result_t got;
    int      errs;
    int      n_results;
    int      n_armed;
    int      n_no_flow;
    int      n_empty;

    // one session update; returns the result the block must produce
    function automatic result_t advance_session(input item_t it);
        result_t           r;
        logic              running;
        logic              gated;
        logic              armed;
        logic [TIME_W-1:0] elapsed;
        logic [PCT_W-1:0]  pct;
        logic [PROD_W-1:0] prod;
        logic [FLOW_W-1:0] thresh;
        r.decision = DEC_KEEP;
        armed      = 1'b0;
        if (it.command == CMD_START)
        begin
            session_start = it.now_ms;
            peak_hold     = '0;
            drop_run      = '0;
            stopped       = 1'b0;
        end
        else
        begin
            running = it.pump_enabled && !stopped;
            gated   = !it.loop_active || it.loop_settled || (it.pump_pwm >= gate_set);
            elapsed = it.now_ms - session_start;
            if (running && it.flow_ml_min > peak_hold)
            begin
                peak_hold = it.flow_ml_min;
                drop_run  = '0;
            end
            armed = running && (elapsed >= TIME_W'(min_run_set)) && gated;
            if (armed)
            begin
                if (peak_hold < min_peak_set)
                begin
                    r.decision = DEC_NO_FLOW;
                    stopped    = 1'b1;
                end
                else
                begin
                    // drop percentage clamps at full scale
                    pct    = (drop_pct_set > PCT_FULL) ? PCT_FULL : drop_pct_set;
                    prod   = PROD_W'(peak_hold) * PROD_W'(PCT_FULL - pct);
                    thresh = FLOW_W'(prod / PROD_W'(PCT_FULL));
                    if (it.flow_ml_min < thresh)
                    begin
                        if (drop_run < CNT_MAX)
                            drop_run = drop_run + 1'b1;
                        if (drop_run >= confirm_set)
                        begin
                            r.decision = DEC_EMPTY;
                            stopped    = 1'b1;
                        end
                    end
                    else
                        drop_run = '0;
                end
            end
        end
        r.peak_flow  = peak_hold;
        r.drop_count = drop_run;
        r.armed      = armed;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_pct_set  = DROP_PCT_RST;
            min_run_set   = MIN_RUN_MS_RST;
            gate_set      = PWM_GATE_LEVEL_RST;
            min_peak_set  = MIN_PEAK_FLOW_RST;
            confirm_set   = CONFIRM_RST;
            session_start = '0;
            peak_hold     = '0;
            drop_run      = '0;
            stopped       = 1'b0;
            due_results.delete();
            errs      = 0;
            n_results = 0;
            n_armed   = 0;
            n_no_flow = 0;
            n_empty   = 0;
        end
        else
        begin
            // register write transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DROP_PCT:       drop_pct_set = cfg_data[PCT_W-1:0];
                    CFG_MIN_RUN_MS:     min_run_set  = cfg_data[15:0];
                    CFG_PWM_GATE_LEVEL: gate_set     = cfg_data[PWM_W-1:0];
                    CFG_MIN_PEAK_FLOW:  min_peak_set = cfg_data[FLOW_W-1:0];
                    CFG_CONFIRM_NEEDED: confirm_set  = cfg_data[CNT_W-1:0];
                    default: ;  // no register behind this index
                endcase
            end

            // input transfer: predict its result
            if (s_axis_tvalid && s_axis_tready)
            begin
                sample_in.command      = command_t'(s_axis_tuser[0]);
                sample_in.now_ms       = s_axis_tdata[31:0];
                sample_in.flow_ml_min  = s_axis_tdata[47:32];
                sample_in.pump_enabled = s_axis_tdata[48];
                sample_in.loop_active  = s_axis_tdata[49];
                sample_in.loop_settled = s_axis_tdata[50];
                sample_in.pump_pwm     = s_axis_tdata[60:51];
                due_results.push_back(advance_session(sample_in));
            end

            // result transfer: compare with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.decision   = decision_t'(m_axis_tdata[1:0]);
                got.peak_flow  = m_axis_tdata[17:2];
                got.drop_count = m_axis_tdata[21:18];
                got.armed      = m_axis_tdata[22];
                n_results++;
                if (due_results.size() == 0)
                begin
                    errs++;
                    if (errs <= MAX_REPORTED)
                        $display("%0t ERROR: result %h with nothing due", $realtime,
                                 m_axis_tdata);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (want.armed)
                        n_armed++;
                    if (want.decision == DEC_NO_FLOW)
                        n_no_flow++;
                    if (want.decision == DEC_EMPTY)
                        n_empty++;
                    if (got.decision !== want.decision || got.peak_flow !== want.peak_flow
                        || got.drop_count !== want.drop_count || got.armed !== want.armed)
                    begin
                        errs++;
                        if (errs <= MAX_REPORTED)
                        begin
                            $display("%0t ERROR: result %0d mismatch", $realtime, n_results);
                            $display("  exp decision %0d peak %0d count %0d armed %0b",
                                     want.decision, want.peak_flow, want.drop_count,
                                     want.armed);
                            $display("  got decision %0d peak %0d count %0d armed %0b",
                                     got.decision, got.peak_flow, got.drop_count, got.armed);
                        end
                    end
                end
            end
        end

        mismatches    <= errs;
        outstanding   <= due_results.size();
        results_seen  <= n_results;
        armed_seen    <= n_armed;
        no_flow_stops <= n_no_flow;
        empty_stops   <= n_empty;
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: top of the drain tank empty detector testbench
// Drives directed and random drain sessions through the block across several
// register settings, with random gaps and result stalls; dted_check predicts
// and compares every result, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import dted_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 650;
    localparam int PHASES        = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 15;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    // register programming styles
    localparam int CFG_LOWEST  = 0;
    localparam int CFG_HIGHEST = 1;
    localparam int CFG_MIXED   = 2;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int mismatches;
    int outstanding;
    int results_seen;
    int armed_seen;
    int no_flow_stops;
    int empty_stops;

    logic        steady     = 1'b0;  // no gaps, no stalls
    int          sent       = 0;
    int          cfg_writes = 0;
    logic [15:0] run_ms_now = MIN_RUN_MS_RST;  // spaces the sample times

    drain_tank_empty_detector DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dted_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .armed_seen    (armed_seen),
        .no_flow_stops (no_flow_stops),
        .empty_stops   (empty_stops)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side stalls
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);

    function automatic item_t make_item(input command_t cmd, input logic [TIME_W-1:0] now,
                                        input logic [FLOW_W-1:0] flow, input logic pump,
                                        input logic active, input logic settled,
                                        input logic [PWM_W-1:0] pwm);
        item_t it;
        it.command      = cmd;
        it.now_ms       = now;
        it.flow_ml_min  = flow;
        it.pump_enabled = pump;
        it.loop_active  = active;
        it.loop_settled = settled;
        it.pump_pwm     = pwm;
        return it;
    endfunction

    // one input transfer; tvalid stays high afterward until the next call
    task automatic push_item(input item_t it);
        while (!steady && $urandom_range(99, 0) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.pump_pwm, it.loop_settled, it.loop_active,
                          it.pump_enabled, it.flow_ml_min, it.now_ms};
        s_axis_tuser  <= it.command;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    // one register write transfer; cfg_valid is lowered by the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_writes++;
    endtask

    // stop input and wait until every result is back and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers; unused upper data bits sometimes carry junk
    task automatic program_regs(input int style);
        logic [PCT_W-1:0]      drop;
        logic [15:0]           run_ms;
        logic [PWM_W-1:0]      gate;
        logic [FLOW_W-1:0]     min_peak;
        logic [CNT_W-1:0]      confirm;
        logic [CFG_DATA_W-1:0] junk;
        logic                  dirty;
        case (style)
            CFG_LOWEST:
            begin
                drop = '0; run_ms = '0; gate = '0; min_peak = '0; confirm = '0;
            end
            CFG_HIGHEST:
            begin
                drop = '1; run_ms = '1; gate = '1; min_peak = '1; confirm = '1;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       drop = PCT_FULL;
                    1:       drop = PCT_W'($urandom_range(101, 127));
                    default: drop = PCT_W'($urandom_range(0, 100));
                endcase
                case ($urandom_range(0, 3))
                    0:       run_ms = 16'd1000;
                    1:       run_ms = 16'd60000;
                    default: run_ms = 16'($urandom_range(1000, 9000));
                endcase
                gate     = PWM_W'($urandom());
                min_peak = ($urandom_range(0, 3) == 0) ? MIN_PEAK_FLOW_RST
                                                       : FLOW_W'($urandom_range(0, 3000));
                confirm  = CNT_W'($urandom());
            end
        endcase
        junk  = 16'($urandom());
        dirty = ($urandom_range(0, 2) == 0);
        write_reg(CFG_DROP_PCT, dirty ? {junk[15:PCT_W], drop} : 16'(drop));
        write_reg(CFG_MIN_RUN_MS, run_ms);
        write_reg(CFG_PWM_GATE_LEVEL, dirty ? {junk[15:PWM_W], gate} : 16'(gate));
        write_reg(CFG_MIN_PEAK_FLOW, min_peak);
        write_reg(CFG_CONFIRM_NEEDED, dirty ? {junk[15:CNT_W], confirm} : 16'(confirm));
        if (style == CFG_HIGHEST || $urandom_range(0, 3) == 0)
            write_reg(CFG_NO_REG, junk);
        cfg_valid  <= 1'b0;
        run_ms_now  = run_ms;
        @(posedge clk);
    endtask

    // a drain session: flow climbs to a peak, then mostly falls away
    task automatic run_session();
        logic [TIME_W-1:0] t;
        int len;
        int turn;
        int top;
        int f;
        int lo_step;
        int hi_step;
        int i;
        t = $urandom();
        // occasionally no start, so the session runs on from the last one
        if ($urandom_range(0, 9) != 0)
            push_item(make_item(CMD_START, t, FLOW_W'($urandom()), 1'($urandom()),
                                1'($urandom()), 1'($urandom()), PWM_W'($urandom())));
        case ($urandom_range(0, 3))
            0:       top = $urandom_range(0, 400);
            1:       top = $urandom_range(60000, 65535);
            default: top = $urandom_range(100, 20000);
        endcase
        lo_step = run_ms_now / 10 + 1;
        hi_step = run_ms_now / 3 + 1;
        len     = $urandom_range(6, 30);
        turn    = $urandom_range(2, len - 2);
        for (i = 0; i < len; i++)
        begin
            t = t + TIME_W'($urandom_range(lo_step, hi_step));
            if (i < turn)
                f = top - $urandom_range(0, top / 16);
            else if ($urandom_range(0, 5) == 0)
                f = top;
            else
                f = $urandom_range(0, top / 2);
            push_item(make_item(CMD_SAMPLE, t, FLOW_W'(f), $urandom_range(0, 9) != 0,
                                1'($urandom()), 1'($urandom()), PWM_W'($urandom())));
        end
    endtask

    // a few unrelated items with every field random
    task automatic noise_burst();
        int n;
        int k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
            push_item(make_item(($urandom_range(0, 7) == 0) ? CMD_START : CMD_SAMPLE,
                                $urandom(), FLOW_W'($urandom()), 1'($urandom()),
                                1'($urandom()), 1'($urandom()), PWM_W'($urandom())));
    endtask

    // watchdog
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still due", CYCLE_LIMIT, outstanding);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int phase;
        int goal;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset register values
        push_item(make_item(CMD_SAMPLE, 32'd9000, 16'd300, 1'b1, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_START, 32'd100, '1, 1'b1, 1'b1, 1'b1, '1));
        push_item(make_item(CMD_SAMPLE, 32'd600, 16'd1000, 1'b1, 1'b1, 1'b0, 10'd0));
        // gate closed just below the level, then open by pwm, settle, loop off
        push_item(make_item(CMD_SAMPLE, 32'd8100, 16'hFFFF, 1'b1, 1'b1, 1'b0, 10'd511));
        push_item(make_item(CMD_SAMPLE, 32'd8200, 16'd0, 1'b1, 1'b1, 1'b0, 10'd512));
        push_item(make_item(CMD_SAMPLE, 32'd8700, 16'd0, 1'b1, 1'b1, 1'b1, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd9200, 16'd0, 1'b1, 1'b0, 1'b0, 10'd0));
        // pump stopped: not armed, counter held
        push_item(make_item(CMD_SAMPLE, 32'd9700, 16'd0, 1'b0, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd10200, 16'd0, 1'b1, 1'b1, 1'b0, '1));
        // finished latch holds everything
        push_item(make_item(CMD_SAMPLE, 32'd10700, 16'd0, 1'b1, 1'b0, 1'b0, '1));
        push_item(make_item(CMD_SAMPLE, '1, '1, 1'b1, 1'b1, 1'b1, '1));
        // elapsed time across the wrap, low peak
        push_item(make_item(CMD_START, 32'hFFFF_FF00, 16'd0, 1'b0, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'h0000_1F00, 16'd150, 1'b1, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'h0000_2000, 16'd5000, 1'b1, 1'b0, 1'b0, 10'd0));
        // run time one short, then exactly reached
        push_item(make_item(CMD_START, '1, 16'd0, 1'b0, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd7998, 16'd500, 1'b1, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd7999, 16'd500, 1'b1, 1'b0, 1'b0, 10'd0));
        // just under and exactly at the threshold, then a new peak
        push_item(make_item(CMD_SAMPLE, 32'd8500, 16'd349, 1'b1, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd9000, 16'd349, 1'b1, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd9500, 16'd350, 1'b1, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd10000, 16'd349, 1'b1, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd10500, 16'd600, 1'b1, 1'b0, 1'b0, 10'd0));
        push_item(make_item(CMD_SAMPLE, 32'd11000, '1, 1'b0, 1'b0, 1'b0, 10'd0));

        // random sessions, one register setting per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            program_regs((phase == 0) ? CFG_LOWEST : (phase == 1) ? CFG_HIGHEST : CFG_MIXED);
            steady <= (phase == 3);
            goal = sent + RANDOM_ITEMS / PHASES;
            while (sent < goal)
            begin
                if ($urandom_range(99, 0) < 85)
                    run_session();
                else
                    noise_burst();
            end
        end
        settle();

        $display("Covered %0d input transfers and %0d register writes over %0d settings.",
                 sent, cfg_writes, PHASES + 1);
        $display("Checked %0d results: %0d armed, %0d no-flow stops, %0d empty stops.",
                 results_seen, armed_seen, no_flow_stops, empty_stops);
        if (outstanding != 0)
            $display("ERROR: %0d results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
